/* rtl/core/cdq_pkg.sv */
// Shared types and constants for the circular double-ended queue.
// Holds the request and response payload structs and the controller/datapath bundles.
// No dependencies.
package cdq_pkg;

   localparam int MAX_SLOTS_DEFAULT = 16;
   localparam int DATA_W            = 32;
   localparam int CAP_W             = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
   localparam logic [1:0] KIND_PUSH_REAR  = 2'd1;
   localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
   localparam logic [1:0] KIND_POP_REAR   = 2'd3;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] popped_value;
      logic [CAP_W-1:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } ctl_cmd_type;

   typedef struct packed {
      logic rsp_blocked;
   } dp_status_type;

endpackage

/* rtl/core/cdq_ctrl.sv */
// Sequencing state machine for the circular double-ended queue.
// Drives the datapath commands and the request stall. Depends on cdq_pkg.
module cdq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cdq_pkg::dp_status_type dp_status,
   output cdq_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD
   } state_type;

   state_type state_ff;
   logic      stall_ff;

   assign req_stall   = stall_ff;
   assign cmd.capture = req_valid && !stall_ff;
   assign cmd.exec    = (state_ff == ST_EXEC);
   assign cmd.load    = (state_ff == ST_LOAD) && !dp_status.rsp_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && !stall_ff) begin
                  state_ff <= ST_EXEC;
                  stall_ff <= 1'b1;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               // Wait here while the previous response is still held.
               if (!dp_status.rsp_blocked) begin
                  state_ff <= ST_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

/* rtl/core/cdq_datapath.sv */
// Datapath of the circular double-ended queue: slot memory, indices, count,
// capacity register and response register. Depends on cdq_pkg.
module cdq_datapath #(
   parameter int MAX_SLOTS = cdq_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cdq_pkg::req_type               req_data,
   input  logic                           csr_valid,
   input  logic [cdq_pkg::CAP_W-1:0]      csr_data,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output cdq_pkg::rsp_type               rsp_data,
   input  cdq_pkg::ctl_cmd_type           cmd,
   output cdq_pkg::dp_status_type         dp_status
);

   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int CAP_W = cdq_pkg::CAP_W;
   localparam int CMP_W = (IDX_W > CAP_W) ? IDX_W : CAP_W;
   localparam logic [CAP_W-1:0] CAP_CLIP =
      (MAX_SLOTS > (2 ** CAP_W) - 1) ? CAP_W'((2 ** CAP_W) - 1) : CAP_W'(MAX_SLOTS);

   logic [cdq_pkg::DATA_W-1:0] mem [MAX_SLOTS];

   logic [CAP_W-1:0]           capacity_ff;
   logic [IDX_W-1:0]           head_ff, head_in;
   logic [IDX_W-1:0]           tail_ff, tail_in;
   logic [CAP_W-1:0]           count_ff, count_in;
   logic [1:0]                 kind_ff;
   logic [cdq_pkg::DATA_W-1:0] value_ff;
   logic [1:0]                 status_ff, status_in;
   logic                       pop_ok_ff, pop_ok_in;
   logic [cdq_pkg::DATA_W-1:0] rd_data_ff;
   logic                       out_valid_ff;
   cdq_pkg::rsp_type           rsp_ff;

   logic [CAP_W-1:0]           eff_cap;
   logic [CAP_W-1:0]           cap_m1;
   logic                       is_push, full, empty;
   logic                       mem_we;
   logic [IDX_W-1:0]           wr_addr, rd_addr;

   function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i,
                                               input logic [CAP_W-1:0] cm1);
      logic [IDX_W-1:0] r;
      if (CMP_W'(i) >= CMP_W'(cm1)) r = '0;
      else                          r = i + IDX_W'(1);
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cm1);
      logic [IDX_W-1:0] r;
      if (i == '0) r = IDX_W'(CMP_W'(cm1));
      else         r = i - IDX_W'(1);
      return r;
   endfunction

   // Zero acts as one, anything above the ring size acts as the ring size.
   always_comb begin
      priority if (capacity_ff == '0)      eff_cap = CAP_W'(1);
      else if (capacity_ff > CAP_CLIP)     eff_cap = CAP_CLIP;
      else                                 eff_cap = capacity_ff;
   end

   assign cap_m1  = eff_cap - CAP_W'(1);
   assign is_push = (kind_ff == cdq_pkg::KIND_PUSH_FRONT) ||
                    (kind_ff == cdq_pkg::KIND_PUSH_REAR);
   assign full    = (count_ff >= eff_cap);
   assign empty   = (count_ff == '0);
   assign rd_addr = (kind_ff == cdq_pkg::KIND_POP_FRONT) ? head_ff : tail_ff;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = cdq_pkg::STATUS_DONE;
      pop_ok_in = 1'b0;
      mem_we    = 1'b0;
      wr_addr   = '0;
      if (is_push) begin
         if (full) begin
            status_in = cdq_pkg::STATUS_FULL;
         end else begin
            mem_we   = 1'b1;
            count_in = count_ff + CAP_W'(1);
            if (empty) begin
               head_in = '0;
               tail_in = '0;
               wr_addr = '0;
            end else if (kind_ff == cdq_pkg::KIND_PUSH_FRONT) begin
               head_in = idx_down(head_ff, cap_m1);
               wr_addr = head_in;
            end else begin
               tail_in = idx_up(tail_ff, cap_m1);
               wr_addr = tail_in;
            end
         end
      end else begin
         if (empty) begin
            status_in = cdq_pkg::STATUS_EMPTY;
         end else begin
            pop_ok_in = 1'b1;
            count_in  = count_ff - CAP_W'(1);
            if (count_in == '0) begin
               head_in = '0;
               tail_in = '0;
            end else if (kind_ff == cdq_pkg::KIND_POP_FRONT) begin
               head_in = idx_up(head_ff, cap_m1);
            end else begin
               tail_in = idx_down(tail_ff, cap_m1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && mem_we) begin
         mem[wr_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_data.kind;
         value_ff <= req_data.push_value;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
      if (cmd.load) begin
         rsp_ff.status       <= status_ff;
         rsp_ff.popped_value <= pop_ok_ff ? rd_data_ff : '0;
         rsp_ff.occupancy    <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= cdq_pkg::CAP_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            capacity_ff <= csr_data;
         end
         if (cmd.exec) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
         if (cmd.load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_data              = rsp_ff;
   assign dp_status.rsp_blocked = out_valid_ff && rsp_stall;

endmodule

/* rtl/core/circular_double_ended_queue_top.sv */
// Top level of the circular double-ended queue.
// Instantiates cdq_ctrl and cdq_datapath; depends on cdq_pkg.

// The queue holds up to capacity words of 32 bits in a ring of MAX_SLOTS
// slots and answers every request (push front, push rear, pop front, pop
// rear) with exactly one response carrying a status, the popped word (zero
// unless a pop succeeded) and the occupancy after the request. A request is
// captured at the edge that accepts it. In the next cycle the indices step
// and the slot memory is written or read through its write port and its
// registered read port; after that, once no earlier response is held, the
// response register is loaded and the response becomes valid. The next
// request is accepted on the cycle after the response register is loaded,
// so the queue takes no new request while one is in flight; a held
// response delays loading only when a second response is ready to be loaded.
// The capacity register is written through the csr port, which is always
// ready, and must only be written while no request is in flight. A capacity
// of zero behaves as one and a capacity above MAX_SLOTS behaves as MAX_SLOTS.
// Slots are not cleared at reset; the queue never returns the contents of a
// slot that it did not write first.
module circular_double_ended_queue_top #(
   parameter int MAX_SLOTS = cdq_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cdq_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cdq_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [cdq_pkg::CAP_W-1:0] csr_data
);

   cdq_pkg::ctl_cmd_type   cmd;
   cdq_pkg::dp_status_type dp_status;

   // Configuration writes complete in the cycle they are presented.
   assign csr_ready = 1'b1;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   cdq_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

endmodule

/* rtl/core/cdq_checker.sv */
// Port-level checks for the circular double-ended queue, bound to the top level.
// Depends on cdq_pkg and circular_double_ended_queue_top.
module cdq_checker #(
   parameter int MAX_SLOTS = cdq_pkg::MAX_SLOTS_DEFAULT
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input cdq_pkg::rsp_type          rsp_data
);

   // Only one request is in flight, so acceptance always raises stall.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held response changed");

   // An empty rejection leaves nothing stored; a full rejection leaves something.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == cdq_pkg::STATUS_EMPTY |-> rsp_data.occupancy == '0)
      else $error("empty rejection with words stored");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == cdq_pkg::STATUS_FULL |-> rsp_data.occupancy != '0)
      else $error("full rejection with an empty queue");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_data.occupancy) <= MAX_SLOTS &&
                    rsp_data.status <= cdq_pkg::STATUS_EMPTY)
      else $error("occupancy beyond ring size or bad status");

endmodule

bind circular_double_ended_queue_top cdq_checker #(
   .MAX_SLOTS (MAX_SLOTS)
) u_cdq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
